### rtl/prrt_pkg.sv
// ----------------------------------------------------------------------------
// prrt_pkg
// types and constants shared by the pending request retransmit table
// ----------------------------------------------------------------------------
`default_nettype none
package prrt_pkg;

	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_REQ   = 2'd1;
	localparam logic [1:0] OP_REPLY = 2'd2;

	localparam logic [2:0] EV_RESEND    = 3'd0;
	localparam logic [2:0] EV_STORED    = 3'd1;
	localparam logic [2:0] EV_PENDING   = 3'd2;
	localparam logic [2:0] EV_UNTRACKED = 3'd3;
	localparam logic [2:0] EV_FULL      = 3'd4;
	localparam logic [2:0] EV_ACK       = 3'd5;
	localparam logic [2:0] EV_UNMATCHED = 3'd6;

	localparam logic [0:0] CFG_TIMEOUT = 1'd0;
	localparam logic [0:0] CFG_RESEND  = 1'd1;

	localparam logic [19:0] TIMEOUT_RESET = 20'd10000;
	localparam logic [15:0] RESEND_RESET  = 16'd1000;
	localparam int          MAX_RESULTS   = 16;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_EVAL,
		ST_OUT_WAIT
	} state_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [7:0]  command_code;
		logic [7:0]  sub_code;
		logic [7:0]  extension;
		logic [31:0] peer_ip;
		logic [15:0] peer_port;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  event_res;
		logic [2:0]  kind;
		logic [7:0]  ext_out;
		logic [31:0] ip_out;
		logic [15:0] port_out;
		logic        last_of_run;
	} out_item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  ext;
		logic [31:0] ip;
		logic [15:0] port;
		logic [31:0] created;
		logic [31:0] last_sent;
	} entry_t;

	function automatic logic [2:0] request_kind(input logic [7:0] code, input logic [7:0] sub);
		logic [2:0] k;
		k = 3'd0;
		if (code == 8'h01) k = 3'd1;
		else if (code == 8'h02) k = 3'd2;
		else if (code == 8'h05 && sub == 8'h01) k = 3'd3;
		else if (code == 8'h05 && sub == 8'h00) k = 3'd4;
		else if (code == 8'h33) k = 3'd5;
		return k;
	endfunction

	function automatic logic [2:0] reply_kind(input logic [7:0] code);
		logic [2:0] k;
		case (code)
			8'hE1: k = 3'd1;
			8'hE2: k = 3'd2;
			8'hE3: k = 3'd3;
			8'hE4: k = 3'd4;
			8'h43: k = 3'd5;
			default: k = 3'd0;
		endcase
		return k;
	endfunction

endpackage
`default_nettype wire

### rtl/prrt_stream_if.sv
// ----------------------------------------------------------------------------
// prrt_stream_if
// valid/ready channel carrying one payload item
// ----------------------------------------------------------------------------
`default_nettype none
interface prrt_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/pending_request_retransmit_table_core.sv
// ----------------------------------------------------------------------------
// pending_request_retransmit_table_core
// request table with reply matching, timeout drop and resend on each tick
// ----------------------------------------------------------------------------
//  channel   dir  payload
//  in_ch     in   operation, command_code, sub_code, extension, peer_ip, peer_port
//  out_ch    out  event_res, kind, ext_out, ip_out, port_out, last_of_run
//  cfg       in   cfg_we, cfg_index, cfg_wdata
//
//  ticks and tracked requests and replies walk the table, a memory read and an
//  evaluate step per entry and a finish step at the end; untracked codes and
//  unknown operations do not walk the table.
//  each resend is held back until the next one so the last one of a tick can be marked.
//  the walk halts in evaluate while a result waits behind the output register.
//  reset clears valid bits, time and registers; memory needs no clearing.
`default_nettype none
module pending_request_retransmit_table_core #(
	parameter int ENTRIES = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	prrt_stream_if.sink   in_ch,
	prrt_stream_if.source out_ch,
	input  wire         cfg_we,
	input  wire  [0:0]  cfg_index,
	input  wire  [19:0] cfg_wdata
);
	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	prrt_pkg::state_t state_q, state_d;
	prrt_pkg::in_item_t item_q;
	logic [19:0] timeout_q;
	logic [15:0] resend_q;
	logic [31:0] now_q;
	logic [ENTRIES-1:0] valid_q;
	logic [IW-1:0] idx_q;
	logic [4:0] nres_q;
	logic [2:0] kind_q;
	logic hit_q;
	logic [IW-1:0] hit_idx_q;
	prrt_pkg::entry_t hit_ent_q;
	logic out_valid_q;
	prrt_pkg::out_item_t out_q;
	logic pend_valid_q;
	prrt_pkg::out_item_t pend_q;
	logic hold_valid_q;
	prrt_pkg::out_item_t hold_q;

	logic mem_we;
	logic [IW-1:0] mem_waddr;
	prrt_pkg::entry_t mem_wdata, rd;

	logic cur_valid, last_idx, matches_key, expire, due;
	logic [31:0] age, since;
	logic free_found;
	logic [IW-1:0] free_idx;
	logic in_fire, can_emit, eval_go, finish_go, resend_hit, in_untracked;
	logic [2:0] in_req_kind, in_rep_kind;
	logic pend_load;
	prrt_pkg::out_item_t pend_d;

	prrt_entry_mem #(.ENTRIES(ENTRIES), .IW(IW)) u_mem (
		.clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
		.raddr(idx_q), .rdata(rd)
	);

	assign cur_valid = valid_q[idx_q];
	assign last_idx = (idx_q == IW'(ENTRIES - 1));
	assign matches_key = cur_valid && rd.kind == kind_q && rd.ext == item_q.extension;
	assign age = now_q - rd.created;
	assign since = now_q - rd.last_sent;
	assign expire = age > {12'd0, timeout_q};
	assign due = since >= {16'd0, resend_q} && nres_q < 5'(prrt_pkg::MAX_RESULTS);
	assign resend_hit = item_q.operation == prrt_pkg::OP_TICK && cur_valid && !expire && due;

	assign in_req_kind = prrt_pkg::request_kind(in_ch.data.command_code, in_ch.data.sub_code);
	assign in_rep_kind = prrt_pkg::reply_kind(in_ch.data.command_code);
	assign in_untracked = (in_ch.data.operation == prrt_pkg::OP_REQ && in_req_kind == 3'd0)
		|| (in_ch.data.operation == prrt_pkg::OP_REPLY && in_rep_kind == 3'd0);

	always_comb begin
		free_found = 1'b0;
		free_idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx = IW'(i);
			end
		end
	end

	assign in_ch.ready = (state_q == prrt_pkg::ST_IDLE) && !pend_valid_q;
	assign out_ch.valid = out_valid_q;
	assign out_ch.data = out_q;

	assign in_fire = in_ch.valid && in_ch.ready;
	assign can_emit = !out_valid_q || out_ch.ready;
	assign eval_go = (state_q == prrt_pkg::ST_SCAN_EVAL) && !pend_valid_q;
	assign finish_go = (state_q == prrt_pkg::ST_OUT_WAIT) && !pend_valid_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			prrt_pkg::ST_IDLE: begin
				if (in_fire && (in_ch.data.operation == prrt_pkg::OP_TICK
					|| (in_ch.data.operation == prrt_pkg::OP_REQ && in_req_kind != 3'd0)
					|| (in_ch.data.operation == prrt_pkg::OP_REPLY
						&& in_rep_kind != 3'd0))) begin
					state_d = prrt_pkg::ST_SCAN_RD;
				end
			end
			prrt_pkg::ST_SCAN_RD: state_d = prrt_pkg::ST_SCAN_EVAL;
			prrt_pkg::ST_SCAN_EVAL: if (eval_go) begin
				state_d = last_idx ? prrt_pkg::ST_OUT_WAIT : prrt_pkg::ST_SCAN_RD;
			end
			prrt_pkg::ST_OUT_WAIT: if (finish_go) state_d = prrt_pkg::ST_IDLE;
			default: state_d = prrt_pkg::ST_IDLE;
		endcase
	end

	// result into the pending slot
	always_comb begin
		pend_load = 1'b0;
		pend_d = hold_q;
		if (in_fire && in_untracked) begin
			pend_load = 1'b1;
			if (in_ch.data.operation == prrt_pkg::OP_REQ)
				pend_d = '{prrt_pkg::EV_UNTRACKED, 3'd0, in_ch.data.extension,
					in_ch.data.peer_ip, in_ch.data.peer_port, 1'b1};
			else
				pend_d = '{prrt_pkg::EV_UNTRACKED, 3'd0, in_ch.data.extension,
					32'd0, 16'd0, 1'b1};
		end else if (eval_go && resend_hit && hold_valid_q) begin
			pend_load = 1'b1;
		end else if (finish_go) begin
			if (item_q.operation == prrt_pkg::OP_TICK) begin
				pend_load = hold_valid_q;
				pend_d.last_of_run = 1'b1;
			end else if (item_q.operation == prrt_pkg::OP_REQ) begin
				pend_load = 1'b1;
				if (hit_q)
					pend_d = '{prrt_pkg::EV_PENDING, kind_q, item_q.extension,
						hit_ent_q.ip, hit_ent_q.port, 1'b1};
				else if (!free_found)
					pend_d = '{prrt_pkg::EV_FULL, kind_q, item_q.extension,
						item_q.peer_ip, item_q.peer_port, 1'b1};
				else
					pend_d = '{prrt_pkg::EV_STORED, kind_q, item_q.extension,
						item_q.peer_ip, item_q.peer_port, 1'b1};
			end else begin
				pend_load = 1'b1;
				if (hit_q)
					pend_d = '{prrt_pkg::EV_ACK, kind_q, item_q.extension,
						hit_ent_q.ip, hit_ent_q.port, 1'b1};
				else
					pend_d = '{prrt_pkg::EV_UNMATCHED, kind_q, item_q.extension,
						32'd0, 16'd0, 1'b1};
			end
		end
	end

	// memory write
	always_comb begin
		mem_we = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = rd;
		if (eval_go && resend_hit) begin
			mem_we = 1'b1;
			mem_wdata.last_sent = now_q;
		end else if (finish_go && item_q.operation == prrt_pkg::OP_REQ
			&& !hit_q && free_found) begin
			mem_we = 1'b1;
			mem_waddr = free_idx;
			mem_wdata = '{kind_q, item_q.extension, item_q.peer_ip, item_q.peer_port,
				now_q, now_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= prrt_pkg::ST_IDLE;
			item_q <= '0;
			timeout_q <= prrt_pkg::TIMEOUT_RESET;
			resend_q <= prrt_pkg::RESEND_RESET;
			now_q <= '0;
			valid_q <= '0;
			idx_q <= '0;
			nres_q <= '0;
			kind_q <= '0;
			hit_q <= 1'b0;
			hit_idx_q <= '0;
			hit_ent_q <= '0;
			out_valid_q <= 1'b0;
			out_q <= '0;
			pend_valid_q <= 1'b0;
			pend_q <= '0;
			hold_valid_q <= 1'b0;
			hold_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					prrt_pkg::CFG_TIMEOUT: timeout_q <= cfg_wdata;
					prrt_pkg::CFG_RESEND: resend_q <= cfg_wdata[15:0];
					default: ;
				endcase
			end
			// output register fed from the pending slot
			if (can_emit) begin
				out_valid_q <= pend_valid_q;
				out_q <= pend_q;
			end
			if (pend_load) begin
				pend_valid_q <= 1'b1;
				pend_q <= pend_d;
			end else if (can_emit) begin
				pend_valid_q <= 1'b0;
			end
			if (in_fire) begin
				item_q <= in_ch.data;
				idx_q <= '0;
				nres_q <= '0;
				hit_q <= 1'b0;
				hold_valid_q <= 1'b0;
				kind_q <= (in_ch.data.operation == prrt_pkg::OP_REQ) ? in_req_kind
					: in_rep_kind;
				if (in_ch.data.operation == prrt_pkg::OP_TICK) now_q <= now_q + 32'd1;
			end
			if (eval_go) begin
				if (!last_idx) idx_q <= idx_q + IW'(1);
				if (item_q.operation == prrt_pkg::OP_TICK) begin
					if (cur_valid && expire) valid_q[idx_q] <= 1'b0;
					else if (resend_hit) begin
						nres_q <= nres_q + 5'd1;
						hold_valid_q <= 1'b1;
						hold_q <= '{prrt_pkg::EV_RESEND, rd.kind, rd.ext,
							rd.ip, rd.port, 1'b0};
					end
				end else if (matches_key && !hit_q) begin
					hit_q <= 1'b1;
					hit_idx_q <= idx_q;
					hit_ent_q <= rd;
				end
			end
			if (finish_go) begin
				hold_valid_q <= 1'b0;
				if (item_q.operation == prrt_pkg::OP_REQ && !hit_q && free_found)
					valid_q[free_idx] <= 1'b1;
				else if (item_q.operation == prrt_pkg::OP_REPLY && hit_q)
					valid_q[hit_idx_q] <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

### rtl/prrt_entry_mem.sv
// ----------------------------------------------------------------------------
// prrt_entry_mem
// entry payload memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module prrt_entry_mem #(
	parameter int ENTRIES = 16,
	parameter int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  wire                   clk,
	input  wire                   we,
	input  wire [IW-1:0]          waddr,
	input  wire prrt_pkg::entry_t wdata,
	input  wire [IW-1:0]          raddr,
	output prrt_pkg::entry_t      rdata
);
	prrt_pkg::entry_t mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### dv/prrt_tb_pkg.sv
// ----------------------------------------------------------------------------
// prrt_tb_pkg
// shared constants for the pending request retransmit table testbench
// ----------------------------------------------------------------------------
package prrt_tb_pkg;

	localparam int         TBL_ENTRIES = 16;
	localparam int         RUN_LIMIT   = 400000;
	localparam logic [1:0] OP_UNUSED   = 2'd3;

endpackage

### dv/pending_request_retransmit_table_checker.sv
// ----------------------------------------------------------------------------
// pending_request_retransmit_table_checker
// watches both channels and the register port, predicts each result of the
// request table from its own copy of the table, and compares field by field
// ----------------------------------------------------------------------------
module pending_request_retransmit_table_checker (
	input  logic        clk,
	input  logic        arst_n,
	prrt_stream_if      in_ch,
	prrt_stream_if      out_ch,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [19:0] cfg_wdata,
	output int          fail_count,
	output int          pending_results
);

	logic [19:0]         timeout_reg;
	logic [15:0]         resend_reg;
	logic [31:0]         clock_ticks;
	logic                slot_used [prrt_tb_pkg::TBL_ENTRIES];
	prrt_pkg::entry_t    slot_data [prrt_tb_pkg::TBL_ENTRIES];
	prrt_pkg::out_item_t expected_results [$];

	function automatic logic [2:0] map_request(logic [7:0] code, logic [7:0] sub);
		case (code)
			8'h01: return 3'd1;
			8'h02: return 3'd2;
			8'h05: return (sub == 8'h01) ? 3'd3 : (sub == 8'h00) ? 3'd4 : 3'd0;
			8'h33: return 3'd5;
			default: return 3'd0;
		endcase
	endfunction

	function automatic logic [2:0] map_reply(logic [7:0] code);
		case (code)
			8'hE1: return 3'd1;
			8'hE2: return 3'd2;
			8'hE3: return 3'd3;
			8'hE4: return 3'd4;
			8'h43: return 3'd5;
			default: return 3'd0;
		endcase
	endfunction

	function automatic int lookup_slot(logic [2:0] k, logic [7:0] ext);
		for (int i = 0; i < prrt_tb_pkg::TBL_ENTRIES; i++)
			if (slot_used[i] && slot_data[i].kind == k && slot_data[i].ext == ext)
				return i;
		return -1;
	endfunction

	function automatic prrt_pkg::out_item_t make_result(logic [2:0] ev, logic [2:0] k,
			logic [7:0] ext, logic [31:0] ip, logic [15:0] port);
		prrt_pkg::out_item_t r;
		r.event_res = ev;
		r.kind = k;
		r.ext_out = ext;
		r.ip_out = ip;
		r.port_out = port;
		r.last_of_run = 1'b0;
		return r;
	endfunction

	task automatic predict_table(prrt_pkg::in_item_t it);
		prrt_pkg::out_item_t run [$];
		logic [2:0]          k;
		int                  hit;
		int                  free_slot;
		if (it.operation == prrt_pkg::OP_TICK) begin
			clock_ticks = clock_ticks + 32'd1;
			for (int i = 0; i < prrt_tb_pkg::TBL_ENTRIES; i++) begin
				if (!slot_used[i])
					continue;
				if (clock_ticks - slot_data[i].created > {12'd0, timeout_reg})
					slot_used[i] = 1'b0;
				else if (clock_ticks - slot_data[i].last_sent >= {16'd0, resend_reg}
						&& run.size() < prrt_pkg::MAX_RESULTS) begin
					slot_data[i].last_sent = clock_ticks;
					run = {run, make_result(prrt_pkg::EV_RESEND, slot_data[i].kind,
						slot_data[i].ext, slot_data[i].ip, slot_data[i].port)};
				end
			end
		end else if (it.operation == prrt_pkg::OP_REQ) begin
			k = map_request(it.command_code, it.sub_code);
			hit = lookup_slot(k, it.extension);
			free_slot = -1;
			for (int i = prrt_tb_pkg::TBL_ENTRIES - 1; i >= 0; i--)
				if (!slot_used[i])
					free_slot = i;
			if (k == 3'd0)
				run = {run, make_result(prrt_pkg::EV_UNTRACKED, 3'd0, it.extension,
					it.peer_ip, it.peer_port)};
			else if (hit >= 0)
				run = {run, make_result(prrt_pkg::EV_PENDING, k, it.extension,
					slot_data[hit].ip, slot_data[hit].port)};
			else if (free_slot < 0)
				run = {run, make_result(prrt_pkg::EV_FULL, k, it.extension, it.peer_ip,
					it.peer_port)};
			else begin
				slot_used[free_slot] = 1'b1;
				slot_data[free_slot] = '{k, it.extension, it.peer_ip, it.peer_port,
					clock_ticks, clock_ticks};
				run = {run, make_result(prrt_pkg::EV_STORED, k, it.extension, it.peer_ip,
					it.peer_port)};
			end
		end else if (it.operation == prrt_pkg::OP_REPLY) begin
			k = map_reply(it.command_code);
			hit = lookup_slot(k, it.extension);
			if (k == 3'd0)
				run = {run, make_result(prrt_pkg::EV_UNTRACKED, 3'd0, it.extension,
					32'd0, 16'd0)};
			else if (hit >= 0) begin
				slot_used[hit] = 1'b0;
				run = {run, make_result(prrt_pkg::EV_ACK, k, it.extension,
					slot_data[hit].ip, slot_data[hit].port)};
			end else
				run = {run, make_result(prrt_pkg::EV_UNMATCHED, k, it.extension,
					32'd0, 16'd0)};
		end
		if (run.size() > 0)
			run[run.size() - 1].last_of_run = 1'b1;
		expected_results = {expected_results, run};
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	task automatic check_result(prrt_pkg::out_item_t got);
		prrt_pkg::out_item_t want;
		if (expected_results.size() == 0) begin
			report_mismatch("unexpected transfer", 32'(got.event_res), 32'd0);
			return;
		end
		want = expected_results.pop_front();
		if (got.event_res !== want.event_res)
			report_mismatch("event_res", 32'(got.event_res), 32'(want.event_res));
		if (got.kind !== want.kind)
			report_mismatch("kind", 32'(got.kind), 32'(want.kind));
		if (got.ext_out !== want.ext_out)
			report_mismatch("ext_out", 32'(got.ext_out), 32'(want.ext_out));
		if (got.ip_out !== want.ip_out)
			report_mismatch("ip_out", got.ip_out, want.ip_out);
		if (got.port_out !== want.port_out)
			report_mismatch("port_out", 32'(got.port_out), 32'(want.port_out));
		if (got.last_of_run !== want.last_of_run)
			report_mismatch("last_of_run", 32'(got.last_of_run), 32'(want.last_of_run));
	endtask

	initial begin
		fail_count = 0;
		pending_results = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_reg = prrt_pkg::TIMEOUT_RESET;
			resend_reg = prrt_pkg::RESEND_RESET;
			clock_ticks = 32'd0;
			for (int i = 0; i < prrt_tb_pkg::TBL_ENTRIES; i++)
				slot_used[i] = 1'b0;
			expected_results.delete();
			pending_results = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == prrt_pkg::CFG_TIMEOUT)
					timeout_reg = cfg_wdata;
				else
					resend_reg = cfg_wdata[15:0];
			end
			if (out_ch.valid && out_ch.ready)
				check_result(out_ch.data);
			if (in_ch.valid && in_ch.ready)
				predict_table(in_ch.data);
			pending_results = expected_results.size();
		end
	end

endmodule

### dv/pending_request_retransmit_table_core_tb.sv
// ----------------------------------------------------------------------------
// pending_request_retransmit_table_core_tb
// drives requests, replies and ticks into the request table under several
// idle patterns and register settings; the checker predicts and compares
// ----------------------------------------------------------------------------
module pending_request_retransmit_table_core_tb;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [0:0]  cfg_index;
	logic [19:0] cfg_wdata;
	int          fail_count;
	int          pending_results;
	int          cycle_count;
	int          send_idle_pct;
	int          recv_stall_pct;
	int          hold_off_cycles;
	logic [7:0]  live_ext [$];
	logic [2:0]  live_kind [$];

	prrt_stream_if #(.payload_t(prrt_pkg::in_item_t))  in_ch ();
	prrt_stream_if #(.payload_t(prrt_pkg::out_item_t)) out_ch ();

	pending_request_retransmit_table_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	pending_request_retransmit_table_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_ch           (in_ch),
		.out_ch          (out_ch),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.fail_count      (fail_count),
		.pending_results (pending_results)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= prrt_tb_pkg::RUN_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// receiver: random stalls, or a long hold-off
	always @(negedge clk) begin
		if (hold_off_cycles > 0) begin
			hold_off_cycles <= hold_off_cycles - 1;
			out_ch.ready <= 1'b0;
		end else
			out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic send_item(prrt_pkg::in_item_t it);
		logic [95:0] junk;
		while ($urandom_range(99) < send_idle_pct) begin
			junk = {$urandom, $urandom, $urandom};
			in_ch.valid <= 1'b0;
			in_ch.data <= junk[$bits(prrt_pkg::in_item_t)-1:0];
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= it;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_op(logic [1:0] op, logic [7:0] code, logic [7:0] sub,
			logic [7:0] ext, logic [31:0] ip, logic [15:0] port);
		prrt_pkg::in_item_t it;
		it = '{op, code, sub, ext, ip, port};
		send_item(it);
	endtask

	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		while (pending_results != 0)
			@(negedge clk);
		repeat (2 * prrt_tb_pkg::TBL_ENTRIES + 8)
			@(negedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [19:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [7:0] request_code_of(logic [2:0] k);
		case (k)
			3'd1: return 8'h01;
			3'd2: return 8'h02;
			3'd5: return 8'h33;
			default: return 8'h05;
		endcase
	endfunction

	function automatic logic [7:0] reply_code_of(logic [2:0] k);
		case (k)
			3'd1: return 8'hE1;
			3'd2: return 8'hE2;
			3'd3: return 8'hE3;
			3'd4: return 8'hE4;
			default: return 8'h43;
		endcase
	endfunction

	// mostly requests and replies of tracked kinds on few extensions, ticks, noise
	task automatic random_item();
		logic [2:0] k;
		logic [7:0] ext;
		int         pick;
		int         sel;
		pick = $urandom_range(99);
		k = 3'($urandom_range(5, 1));
		ext = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(5));
		if (pick < 35)
			send_op(prrt_pkg::OP_TICK, 8'($urandom), 8'($urandom), 8'($urandom),
				$urandom, 16'($urandom));
		else if (pick < 65) begin
			send_op(prrt_pkg::OP_REQ, request_code_of(k), (k == 3'd3) ? 8'h01 : (k == 3'd4)
				? 8'h00 : 8'($urandom), ext, $urandom, 16'($urandom));
			live_kind = {live_kind, k};
			live_ext = {live_ext, ext};
		end else if (pick < 88 && live_ext.size() > 0) begin
			sel = $urandom_range(live_ext.size() - 1);
			send_op(prrt_pkg::OP_REPLY, reply_code_of(live_kind[sel]), 8'($urandom),
				live_ext[sel], $urandom, 16'($urandom));
			live_kind.delete(sel);
			live_ext.delete(sel);
		end else if (pick < 94)
			send_op(prrt_pkg::OP_REPLY, ($urandom_range(1) ? reply_code_of(k)
				: 8'($urandom)), 8'($urandom), ext, $urandom, 16'($urandom));
		else if (pick < 98)
			send_op(prrt_pkg::OP_REQ, 8'($urandom), 8'($urandom), ext, $urandom,
				16'($urandom));
		else
			send_op(prrt_tb_pkg::OP_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom),
				$urandom, 16'($urandom));
	endtask

	initial begin
		arst_n = 1'b0;
		cycle_count = 0;
		cfg_we = 1'b0;
		cfg_index = prrt_pkg::CFG_TIMEOUT;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off_cycles = 0;
		repeat (8)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: every request code, extremes, pending, full, untracked, overflow
		write_reg(prrt_pkg::CFG_TIMEOUT, 20'd6);
		write_reg(prrt_pkg::CFG_RESEND, 20'd1);
		send_op(prrt_pkg::OP_REQ, 8'h01, 8'h00, 8'h00, 32'h0, 16'h0);
		send_op(prrt_pkg::OP_REQ, 8'h02, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF);
		send_op(prrt_pkg::OP_REQ, 8'h05, 8'h01, 8'h10, 32'h1234_5678, 16'h4321);
		send_op(prrt_pkg::OP_REQ, 8'h05, 8'h00, 8'h10, 32'hA5A5_5A5A, 16'h00FF);
		send_op(prrt_pkg::OP_REQ, 8'h05, 8'h02, 8'h10, 32'h1, 16'h1);
		send_op(prrt_pkg::OP_REQ, 8'h33, 8'h00, 8'h7F, 32'h8000_0000, 16'h8000);
		send_op(prrt_pkg::OP_REQ, 8'h01, 8'h00, 8'h00, 32'hDEAD_BEEF, 16'h1111);
		send_op(prrt_pkg::OP_REQ, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF);
		send_op(prrt_pkg::OP_REPLY, 8'hE2, 8'h00, 8'hFF, 32'h0, 16'h0);
		send_op(prrt_pkg::OP_REPLY, 8'hE3, 8'h00, 8'h10, 32'h0, 16'h0);
		send_op(prrt_pkg::OP_REPLY, 8'hE4, 8'h00, 8'h11, 32'h0, 16'h0);
		send_op(prrt_pkg::OP_REPLY, 8'h43, 8'h00, 8'h7F, 32'h0, 16'h0);
		send_op(prrt_pkg::OP_REPLY, 8'h00, 8'hFF, 8'h55, 32'hFFFF_FFFF, 16'hFFFF);
		send_op(prrt_tb_pkg::OP_UNUSED, 8'h01, 8'h00, 8'h00, 32'h0, 16'h0);
		for (int i = 0; i < 18; i++)
			send_op(prrt_pkg::OP_REQ, 8'h01, 8'h00, 8'(i + 1), 32'($urandom),
				16'($urandom));
		repeat (8)
			send_op(prrt_pkg::OP_TICK, 8'h00, 8'h00, 8'h00, 32'h0, 16'h0);
		wait_idle();

		// random phases over idle patterns and register settings
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
				default: begin send_idle_pct = 35; recv_stall_pct = 35; end
			endcase
			case (ph)
				0: begin
					write_reg(prrt_pkg::CFG_TIMEOUT, 20'd1);
					write_reg(prrt_pkg::CFG_RESEND, 20'd1);
				end
				1: begin
					write_reg(prrt_pkg::CFG_TIMEOUT, 20'd40);
					write_reg(prrt_pkg::CFG_RESEND, 20'd3);
				end
				2: begin
					write_reg(prrt_pkg::CFG_TIMEOUT, 20'd1000000);
					write_reg(prrt_pkg::CFG_RESEND, 20'd65535);
				end
				3: begin
					write_reg(prrt_pkg::CFG_TIMEOUT, 20'd0);
					write_reg(prrt_pkg::CFG_RESEND, 20'd0);
				end
				4: begin
					write_reg(prrt_pkg::CFG_TIMEOUT, 20'hFFFFF);
					write_reg(prrt_pkg::CFG_RESEND, 20'd2);
				end
				5: begin
					write_reg(prrt_pkg::CFG_TIMEOUT, 20'd15);
					write_reg(prrt_pkg::CFG_RESEND, 20'h0FFFF);
				end
				6: begin
					write_reg(prrt_pkg::CFG_TIMEOUT, 20'd25);
					write_reg(prrt_pkg::CFG_RESEND, 20'd1);
				end
				default: begin
					write_reg(prrt_pkg::CFG_TIMEOUT, 20'd10000);
					write_reg(prrt_pkg::CFG_RESEND, 20'd5);
				end
			endcase
			if (ph == 4)
				hold_off_cycles = 400;
			repeat (46)
				random_item();
			wait_idle();
			live_ext.delete();
			live_kind.delete();
		end

		wait_idle();
		if (fail_count == 0 && pending_results == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

### sim.f
rtl/prrt_pkg.sv
rtl/prrt_stream_if.sv
rtl/prrt_entry_mem.sv
rtl/pending_request_retransmit_table_core.sv
dv/prrt_tb_pkg.sv
dv/pending_request_retransmit_table_checker.sv
dv/pending_request_retransmit_table_core_tb.sv
